// ===== rtl/foae_pkg.sv =====
package foae_pkg;

    localparam int SAMPLE_BITS_DEF = 16;
    localparam int ANGLE_BITS_DEF  = 16;

    // elevation control is Q0.16, angle (c - 0.5) * 2 rad
    localparam int EL_BITS  = 16;
    localparam int EL_SHIFT = 30 - (EL_BITS - 1);

    localparam logic [31:0]        Q30_ONE     = 32'h4000_0000;
    localparam logic [30:0]        HALF_PI_Q30 = 31'd1686629713;
    localparam logic signed [31:0] W_GAIN_Q30  = 32'sd759135470;

    // Horner terms of the sine polynomial, one cell each
    localparam int N_TERMS     = 5;
    localparam int CELL_STAGES = 3;
    // x^2 stage, cells, x*t stage, cap/sign stage
    localparam int SINE_LAT    = 1 + CELL_STAGES * N_TERMS + 2;
    // angle front stage, sine chain, product stage, round/saturate stage
    localparam int PIPE_DEPTH  = 1 + SINE_LAT + 2;

    typedef struct packed {
        logic [31:0] x2;
        logic [30:0] t;
        logic [30:0] x;
        logic        neg;
    } t_term;

    function automatic int term_div(input int idx);
        int d;
        case (idx)
            0:       d = 110;
            1:       d = 72;
            2:       d = 42;
            3:       d = 20;
            default: d = 6;
        endcase
        return d;
    endfunction

endpackage

// ===== rtl/foae_cell.sv =====
module foae_cell #(
    parameter int DIVISOR = 6
) (
    input  logic            i_clk,
    input  logic            i_en,
    input  foae_pkg::t_term i_term,
    output foae_pkg::t_term o_term
);

    localparam logic [31:0] RECIP = 32'((64'd1 << 32) / DIVISOR);
    localparam logic [31:0] DIV_W = 32'(DIVISOR);

    // stage A: x2 * t
    logic [62:0]     a_prod;
    logic [31:0]     n_a_p;
    logic [31:0]     r_a_p;
    foae_pkg::t_term r_a_term;

    // stage B: reciprocal estimate of the quotient, low by at most one
    logic [63:0]     b_prod;
    logic [31:0]     n_b_q0;
    logic [31:0]     r_b_q0;
    logic [31:0]     r_b_p;
    foae_pkg::t_term r_b_term;

    // stage C: correct quotient, t = 1 - q
    logic [31:0]     c_qd;
    logic [31:0]     c_rem;
    logic [31:0]     c_q;
    logic [31:0]     c_t;
    foae_pkg::t_term n_c_term;
    foae_pkg::t_term r_c_term;

    assign a_prod = 63'(i_term.x2) * 63'(i_term.t);
    assign n_a_p  = a_prod[61:30];

    assign b_prod = 64'(r_a_p) * 64'(RECIP);
    assign n_b_q0 = b_prod[63:32];

    assign c_qd  = r_b_q0 * DIV_W;
    assign c_rem = r_b_p - c_qd;
    assign c_q   = (c_rem >= DIV_W) ? r_b_q0 + 32'd1 : r_b_q0;
    assign c_t   = foae_pkg::Q30_ONE - c_q;

    always_comb begin
        n_c_term   = r_b_term;
        n_c_term.t = c_t[30:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_p    <= n_a_p;
            r_a_term <= i_term;
            r_b_q0   <= n_b_q0;
            r_b_p    <= r_a_p;
            r_b_term <= r_a_term;
            r_c_term <= n_c_term;
        end
    end

    assign o_term = r_c_term;

endmodule

// ===== rtl/foae_front.sv =====
module foae_front #(
    parameter int ANGLE_BITS = foae_pkg::ANGLE_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_en,
    input  logic [ANGLE_BITS-1:0] i_angle,
    output logic [30:0]           o_x,
    output logic                  o_neg
);

    localparam int QW = ANGLE_BITS - 2;
    localparam int PW = QW + 32;

    logic [1:0]    quad;
    logic [QW-1:0] low;
    logic [QW:0]   fold;
    logic [PW-1:0] prod;
    logic [30:0]   r_x;
    logic          r_neg;

    assign quad = i_angle[ANGLE_BITS-1 -: 2];
    assign low  = i_angle[QW-1:0];
    // odd quadrants run backward from the quarter turn
    assign fold = quad[0] ? {1'b1, {QW{1'b0}}} - {1'b0, low} : {1'b0, low};
    assign prod = PW'(fold) * PW'(foae_pkg::HALF_PI_Q30);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x   <= prod[QW +: 31];
            r_neg <= quad[1];
        end
    end

    assign o_x   = r_x;
    assign o_neg = r_neg;

endmodule

// ===== rtl/foae_sine.sv =====
module foae_sine (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic [30:0]        i_x,
    input  logic               i_neg,
    output logic signed [31:0] o_coeff
);

    logic [61:0]        sq_prod;
    foae_pkg::t_term    n_head;
    foae_pkg::t_term    r_head;
    foae_pkg::t_term    w_term [foae_pkg::N_TERMS+1];

    logic [61:0]        f_prod;
    logic [31:0]        r_f_s;
    logic               r_f_neg;
    logic [31:0]        f_cap;
    logic signed [31:0] n_coeff;
    logic signed [31:0] r_coeff;

    assign sq_prod = 62'(i_x) * 62'(i_x);

    always_comb begin
        n_head.x2  = sq_prod[61:30];
        n_head.t   = foae_pkg::Q30_ONE[30:0];
        n_head.x   = i_x;
        n_head.neg = i_neg;
    end

    assign w_term[0] = r_head;

    for (genvar k = 0; k < foae_pkg::N_TERMS; k++) begin : g_cell
        foae_cell #(
            .DIVISOR(foae_pkg::term_div(k))
        ) u_cell (
            .i_clk (i_clk),
            .i_en  (i_en),
            .i_term(w_term[k]),
            .o_term(w_term[k+1])
        );
    end

    assign f_prod = 62'(w_term[foae_pkg::N_TERMS].x) * 62'(w_term[foae_pkg::N_TERMS].t);

    assign f_cap   = (r_f_s > foae_pkg::Q30_ONE) ? foae_pkg::Q30_ONE : r_f_s;
    assign n_coeff = r_f_neg ? -$signed(f_cap) : $signed(f_cap);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_head  <= n_head;
            r_f_s   <= f_prod[61:30];
            r_f_neg <= w_term[foae_pkg::N_TERMS].neg;
            r_coeff <= n_coeff;
        end
    end

    assign o_coeff = r_coeff;

endmodule

// ===== rtl/foae_scale.sv =====
module foae_scale #(
    parameter int SAMPLE_BITS = foae_pkg::SAMPLE_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    input  logic signed [31:0]            i_coeff,
    output logic signed [SAMPLE_BITS-1:0] o_value
);

    localparam int PW = SAMPLE_BITS + 32;
    localparam logic signed [PW-1:0]          HALF_LSB = PW'(64'sd1 <<< 29);
    localparam logic signed [SAMPLE_BITS-1:0] MAX_VAL  = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] MIN_VAL  = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    logic signed [PW-1:0]          n_prod;
    logic signed [PW-1:0]          r_prod;
    logic signed [PW-1:0]          rnd;
    logic [SAMPLE_BITS+1:0]        q;
    logic signed [SAMPLE_BITS-1:0] n_value;
    logic signed [SAMPLE_BITS-1:0] r_value;

    assign n_prod = PW'(i_sample) * PW'(i_coeff);

    // round half up, then clamp to the sample range
    assign rnd = r_prod + HALF_LSB;
    assign q   = rnd[PW-1:30];

    always_comb begin
        if (q[SAMPLE_BITS+1 -: 3] == 3'b000 || q[SAMPLE_BITS+1 -: 3] == 3'b111) begin
            n_value = q[SAMPLE_BITS-1:0];
        end else if (q[SAMPLE_BITS+1]) begin
            n_value = MIN_VAL;
        end else begin
            n_value = MAX_VAL;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod  <= n_prod;
            r_value <= n_value;
        end
    end

    assign o_value = r_value;

endmodule

// ===== rtl/first_order_ambisonic_encoder.sv =====
// First-order B-format encoder. Each request (sample, azimuth, elevation) yields
// W, X, Y, Z; a new request can be taken every cycle while the output is not
// stalled. Depth is set by the three sine chains (cos azimuth, sin azimuth,
// sin elevation), each a row of five polynomial cells of three stages apiece,
// plus angle conversion, x^2, x*t, cap/sign, product and round/saturate stages.
// A stall on the output freezes the whole pipeline; o_stall comes from a flop
// (one-entry skid on the input), so one more request is still taken at the
// cycle the pipeline freezes. No configuration, no state between samples.
module first_order_ambisonic_encoder #(
    parameter int SAMPLE_BITS = foae_pkg::SAMPLE_BITS_DEF,
    parameter int ANGLE_BITS  = foae_pkg::ANGLE_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic signed [SAMPLE_BITS-1:0]       i_audio_sample,
    input  logic [ANGLE_BITS-1:0]               i_azimuth_angle,
    input  logic [foae_pkg::EL_BITS-1:0]        i_elevation_control,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic signed [SAMPLE_BITS-1:0]       o_w_channel,
    output logic signed [SAMPLE_BITS-1:0]       o_x_channel,
    output logic signed [SAMPLE_BITS-1:0]       o_y_channel,
    output logic signed [SAMPLE_BITS-1:0]       o_z_channel
);

    localparam int EB    = foae_pkg::EL_BITS;
    localparam int DEPTH = foae_pkg::PIPE_DEPTH;
    localparam int SDLY  = foae_pkg::SINE_LAT;
    localparam logic [ANGLE_BITS-1:0] QUARTER = {2'b01, {(ANGLE_BITS-2){1'b0}}};
    localparam logic [EB:0]           EL_MID  = {2'b01, {(EB-1){1'b0}}};

    logic                          in_acc;
    logic                          en;
    logic                          s0_valid;

    logic                          r_skid_valid;
    logic signed [SAMPLE_BITS-1:0] r_skid_sample;
    logic [ANGLE_BITS-1:0]         r_skid_az;
    logic [EB-1:0]                 r_skid_el;

    logic signed [SAMPLE_BITS-1:0] sel_sample;
    logic [ANGLE_BITS-1:0]         sel_az;
    logic [ANGLE_BITS-1:0]         sel_az_cos;
    logic [EB-1:0]                 sel_el;

    logic [EB-1:0]                 el_mag;
    logic [30:0]                   r_el_x;
    logic                          r_el_neg;
    logic signed [SAMPLE_BITS-1:0] r_s1_sample;

    logic [30:0]                   cos_x;
    logic                          cos_neg;
    logic [30:0]                   sin_x;
    logic                          sin_neg;

    logic signed [31:0]            cos_coeff;
    logic signed [31:0]            sin_coeff;
    logic signed [31:0]            el_coeff;

    logic signed [SAMPLE_BITS-1:0] r_smp_dly [SDLY];
    logic [DEPTH-1:0]              r_vld;

    assign o_stall  = r_skid_valid;
    assign in_acc   = i_valid && !r_skid_valid;
    assign en       = !(r_vld[DEPTH-1] && i_stall);
    assign s0_valid = r_skid_valid || in_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skid_valid <= 1'b0;
        end else if (en) begin
            r_skid_valid <= 1'b0;
        end else if (in_acc) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!en && in_acc) begin
            r_skid_sample <= i_audio_sample;
            r_skid_az     <= i_azimuth_angle;
            r_skid_el     <= i_elevation_control;
        end
    end

    assign sel_sample = r_skid_valid ? r_skid_sample : i_audio_sample;
    assign sel_az     = r_skid_valid ? r_skid_az : i_azimuth_angle;
    assign sel_el     = r_skid_valid ? r_skid_el : i_elevation_control;
    assign sel_az_cos = sel_az + QUARTER;

    // elevation magnitude |c - mid|, negative below mid
    assign el_mag = sel_el[EB-1] ? {1'b0, sel_el[EB-2:0]} : EB'(EL_MID - {1'b0, sel_el});

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_el_x      <= {el_mag, {foae_pkg::EL_SHIFT{1'b0}}};
            r_el_neg    <= !sel_el[EB-1];
            r_s1_sample <= sel_sample;
        end
    end

    foae_front #(.ANGLE_BITS(ANGLE_BITS)) u_front_cos (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_angle(sel_az_cos),
        .o_x    (cos_x),
        .o_neg  (cos_neg)
    );

    foae_front #(.ANGLE_BITS(ANGLE_BITS)) u_front_sin (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_angle(sel_az),
        .o_x    (sin_x),
        .o_neg  (sin_neg)
    );

    foae_sine u_sine_cos (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_x    (cos_x),
        .i_neg  (cos_neg),
        .o_coeff(cos_coeff)
    );

    foae_sine u_sine_sin (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_x    (sin_x),
        .i_neg  (sin_neg),
        .o_coeff(sin_coeff)
    );

    foae_sine u_sine_el (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_x    (r_el_x),
        .i_neg  (r_el_neg),
        .o_coeff(el_coeff)
    );

    // sample rides alongside the sine chains
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_smp_dly[0] <= r_s1_sample;
            for (int k = 1; k < SDLY; k++) begin
                r_smp_dly[k] <= r_smp_dly[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[DEPTH-2:0], s0_valid};
        end
    end

    assign o_valid = r_vld[DEPTH-1];

    foae_scale #(.SAMPLE_BITS(SAMPLE_BITS)) u_scale_w (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_sample(r_smp_dly[SDLY-1]),
        .i_coeff (foae_pkg::W_GAIN_Q30),
        .o_value (o_w_channel)
    );

    foae_scale #(.SAMPLE_BITS(SAMPLE_BITS)) u_scale_x (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_sample(r_smp_dly[SDLY-1]),
        .i_coeff (cos_coeff),
        .o_value (o_x_channel)
    );

    foae_scale #(.SAMPLE_BITS(SAMPLE_BITS)) u_scale_y (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_sample(r_smp_dly[SDLY-1]),
        .i_coeff (sin_coeff),
        .o_value (o_y_channel)
    );

    foae_scale #(.SAMPLE_BITS(SAMPLE_BITS)) u_scale_z (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_sample(r_smp_dly[SDLY-1]),
        .i_coeff (el_coeff),
        .o_value (o_z_channel)
    );

endmodule

// ===== tb/tb_first_order_ambisonic_encoder.sv =====
module tb_first_order_ambisonic_encoder;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SB = foae_pkg::SAMPLE_BITS_DEF;
    localparam int AB = foae_pkg::ANGLE_BITS_DEF;
    localparam int EB = foae_pkg::EL_BITS;
    localparam bit [63:0] ONE_Q30 = 64'd1 << 30;
    localparam bit [63:0] QUARTER = 64'd1 << (AB - 2);
    localparam int N_RAND_A = 400;
    localparam int N_RAND_B = 430;

    typedef struct {
        logic signed [SB-1:0] smp;
        logic [AB-1:0]        az;
        logic [EB-1:0]        el;
    } t_bf_request;

    typedef struct {
        logic signed [SB-1:0] w;
        logic signed [SB-1:0] x;
        logic signed [SB-1:0] y;
        logic signed [SB-1:0] z;
    } t_bf_channels;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_valid = 1'b0;
    logic                 o_stall;
    logic signed [SB-1:0] i_audio_sample = '0;
    logic [AB-1:0]        i_azimuth_angle = '0;
    logic [EB-1:0]        i_elevation_control = '0;
    logic                 o_valid;
    logic                 i_stall = 1'b0;
    logic signed [SB-1:0] o_w_channel;
    logic signed [SB-1:0] o_x_channel;
    logic signed [SB-1:0] o_y_channel;
    logic signed [SB-1:0] o_z_channel;

    t_bf_request  pending_reqs[$];
    t_bf_channels expected_bf[$];
    t_bf_request  cur_req = '{default: '0};

    int n_sent = 0;
    int n_checked = 0;
    int n_errors = 0;
    int n_backpressure = 0;

    first_order_ambisonic_encoder u_top (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_valid             (i_valid),
        .o_stall             (o_stall),
        .i_audio_sample      (i_audio_sample),
        .i_azimuth_angle     (i_azimuth_angle),
        .i_elevation_control (i_elevation_control),
        .o_valid             (o_valid),
        .i_stall             (i_stall),
        .o_w_channel         (o_w_channel),
        .o_x_channel         (o_x_channel),
        .o_y_channel         (o_y_channel),
        .o_z_channel         (o_z_channel)
    );

    always #2 i_clk = ~i_clk;

    // Horner series for sine of a Q2.30 angle in [0, pi/2]
    function automatic bit [63:0] poly_sine_q30(input bit [63:0] ang);
        bit [63:0] x2;
        bit [63:0] t;
        x2 = (ang * ang) >> 30;
        t = ONE_Q30;
        t = ONE_Q30 - (((x2 * t) >> 30) / 110);
        t = ONE_Q30 - (((x2 * t) >> 30) / 72);
        t = ONE_Q30 - (((x2 * t) >> 30) / 42);
        t = ONE_Q30 - (((x2 * t) >> 30) / 20);
        t = ONE_Q30 - (((x2 * t) >> 30) / 6);
        t = (ang * t) >> 30;
        return (t > ONE_Q30) ? ONE_Q30 : t;
    endfunction

    // sine of a binary angle, quadrant folded, signed Q2.30
    function automatic longint turn_sine_q30(input bit [63:0] ang);
        bit [63:0] quad;
        bit [63:0] r;
        bit [63:0] rad;
        longint    s;
        ang  = ang & ((64'd1 << AB) - 1);
        quad = ang >> (AB - 2);
        r    = ang & (QUARTER - 1);
        if (quad[0]) begin
            r = QUARTER - r;
        end
        rad = (r * 64'(foae_pkg::HALF_PI_Q30)) >> (AB - 2);
        s   = longint'(poly_sine_q30(rad));
        return quad[1] ? -s : s;
    endfunction

    function automatic logic signed [SB-1:0] gain_round_sat(input longint smp,
                                                            input longint coeff);
        longint p;
        longint r;
        longint lim;
        lim = longint'(1) <<< (SB - 1);
        p   = smp * coeff;
        r   = (p + 64'sd536870912) >>> 30;
        if (r > lim - 1) begin
            r = lim - 1;
        end
        if (r < -lim) begin
            r = -lim;
        end
        return r[SB-1:0];
    endfunction

    function automatic t_bf_channels encode_bformat(input t_bf_request req);
        t_bf_channels ch;
        longint       smp;
        longint       zc;
        bit [63:0]    el;
        smp = longint'(req.smp);
        el  = 64'(req.el);
        if (el >= 64'd32768) begin
            zc = longint'(poly_sine_q30((el - 64'd32768) << 15));
        end else begin
            zc = -longint'(poly_sine_q30((64'd32768 - el) << 15));
        end
        ch.w = gain_round_sat(smp, longint'(foae_pkg::W_GAIN_Q30));
        ch.x = gain_round_sat(smp, turn_sine_q30(64'(req.az) + QUARTER));
        ch.y = gain_round_sat(smp, turn_sine_q30(64'(req.az)));
        ch.z = gain_round_sat(smp, zc);
        return ch;
    endfunction

    task automatic queue_request(input int smp, input int az, input int el);
        t_bf_request req;
        req.smp = smp[SB-1:0];
        req.az  = az[AB-1:0];
        req.el  = el[EB-1:0];
        pending_reqs.push_back(req);
    endtask

    task automatic queue_random(input int n);
        int pick;
        int smp;
        int az;
        int el;
        for (int k = 0; k < n; k++) begin
            pick = $urandom_range(0, 9);
            smp  = $urandom_range(0, 65535);
            az   = $urandom_range(0, 65535);
            el   = $urandom_range(0, 65535);
            // corners now and then: full-scale samples, quadrant edges, elevation ends
            if (pick == 0) begin
                smp = ($urandom_range(0, 1) != 0) ? 32767 : -32768;
                az  = $urandom_range(0, 3) * 16384 + $urandom_range(0, 2) - 1;
            end else if (pick == 1) begin
                el = ($urandom_range(0, 1) != 0) ? $urandom_range(0, 3)
                                                 : 65535 - $urandom_range(0, 3);
            end
            queue_request(smp, az, el);
        end
    endtask

    task automatic check_chan(input string nm, input logic signed [SB-1:0] exp_v,
                              input logic signed [SB-1:0] act_v);
        if (exp_v !== act_v) begin
            n_errors++;
            $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, nm, exp_v, act_v);
        end
    endtask

    // request driver
    int src_gap = 0;
    int src_calm = 0;

    always @(posedge i_clk) begin
        logic v;
        int   r;
        v = i_valid;
        if (!i_rst_n) begin
            v = 1'b0;
        end else begin
            if (i_valid && o_stall) begin
                n_backpressure++;
            end
            if (i_valid && !o_stall) begin
                expected_bf.push_back(encode_bformat(cur_req));
                n_sent++;
                v = 1'b0;
                if (src_calm > 0) begin
                    src_calm--;
                end else begin
                    r = $urandom_range(0, 99);
                    if (r < 4) begin
                        src_calm = $urandom_range(20, 60);
                    end else if (r < 30) begin
                        src_gap = $urandom_range(1, 3);
                    end else if (r < 33) begin
                        src_gap = $urandom_range(10, 40);
                    end
                end
            end
            if (!v) begin
                if (src_gap > 0) begin
                    src_gap--;
                end else if (pending_reqs.size() > 0) begin
                    cur_req = pending_reqs.pop_front();
                    v = 1'b1;
                end
            end
        end
        i_valid             <= v;
        i_audio_sample      <= cur_req.smp;
        i_azimuth_angle     <= cur_req.az;
        i_elevation_control <= cur_req.el;
    end

    // receiver stall; two long hold-offs let the pipe fill and push back on the input
    int sink_seen = 0;
    int sink_hold = 0;
    int sink_calm = 0;
    int sink_stall = 0;

    always @(posedge i_clk) begin
        logic s;
        int   r;
        s = 1'b0;
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                sink_seen++;
                if (sink_seen == 300 || sink_seen == 650) begin
                    sink_hold = 150;
                end
            end
            if (sink_hold > 0) begin
                sink_hold--;
                s = 1'b1;
            end else if (sink_calm > 0) begin
                sink_calm--;
            end else begin
                if (sink_stall == 0) begin
                    r = $urandom_range(0, 99);
                    if (r < 4) begin
                        sink_calm = $urandom_range(20, 80);
                    end else if (r < 30) begin
                        sink_stall = $urandom_range(1, 3);
                    end else if (r < 33) begin
                        sink_stall = $urandom_range(10, 40);
                    end
                end
                if (sink_stall > 0) begin
                    sink_stall--;
                    s = 1'b1;
                end
            end
        end
        i_stall <= s;
    end

    // result monitor
    always @(posedge i_clk) begin
        t_bf_channels exp_ch;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_bf.size() == 0) begin
                n_errors++;
                $display("%0t ns: result with nothing expected, got w=%0d x=%0d y=%0d z=%0d",
                         $time, o_w_channel, o_x_channel, o_y_channel, o_z_channel);
            end else begin
                exp_ch = expected_bf.pop_front();
                check_chan("w_channel", exp_ch.w, o_w_channel);
                check_chan("x_channel", exp_ch.x, o_x_channel);
                check_chan("y_channel", exp_ch.y, o_y_channel);
                check_chan("z_channel", exp_ch.z, o_z_channel);
                n_checked++;
            end
        end
    end

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // +-full-scale samples vs +-1 coefficients, quadrant edges, elevation ends
        queue_request(-32768, 0, 32768);
        queue_request(-32768, 32768, 32768);
        queue_request(-32768, 16384, 65535);
        queue_request(-32768, 49152, 0);
        queue_request(-32768, 65535, 0);
        queue_request(32767, 0, 0);
        queue_request(32767, 65535, 65535);
        queue_request(32767, 32768, 65535);
        queue_request(32767, 49151, 65534);
        queue_request(0, 12345, 1000);
        queue_request(0, 0, 0);
        queue_request(-1, 8192, 32767);
        queue_request(1, 24576, 32769);
        queue_request(-16384, 40960, 16384);
        queue_request(16384, 57344, 49152);
        queue_request(-32767, 16383, 1);
        queue_request(-32768, 16385, 32768);
        queue_request(32767, 32767, 32768);

        // sender waits for a full drain between phases
        while (pending_reqs.size() != 0 || i_valid || expected_bf.size() != 0)
            @(negedge i_clk);
        queue_random(N_RAND_A);
        while (pending_reqs.size() != 0 || i_valid || expected_bf.size() != 0)
            @(negedge i_clk);
        queue_random(N_RAND_B);

        while (pending_reqs.size() != 0 || i_valid) @(negedge i_clk);
        while (expected_bf.size() != 0) @(negedge i_clk);
        repeat (2 * foae_pkg::PIPE_DEPTH) @(negedge i_clk);

        if (expected_bf.size() != 0) begin
            n_errors++;
            $display("%0t ns: %0d results never arrived", $time, expected_bf.size());
        end
        $display("Covered %0d requests (corner cases plus random samples, azimuths, elevations)",
                 n_sent);
        $display("%0d results checked, %0d cycles of input back-pressure, %0d errors",
                 n_checked, n_backpressure, n_errors);
        if (n_errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("Timeout after %0d requests, %0d results", n_sent, n_checked);
        $display("FAILURE");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/foae_pkg.sv
rtl/foae_cell.sv
rtl/foae_front.sv
rtl/foae_sine.sv
rtl/foae_scale.sv
rtl/first_order_ambisonic_encoder.sv
tb/tb_first_order_ambisonic_encoder.sv
